// ===== rtl/uer_pkg.sv =====
package uer_pkg;

  localparam int unsigned TICKS_PER_MS  = 1000;
  localparam int unsigned TRIGGER_TICKS = 11;
  localparam int unsigned MIN_PULSE_US  = 174;

  localparam int unsigned PulseW = 16;
  localparam int unsigned MsW    = 10;
  localparam int unsigned TrigW  = 4;
  localparam int unsigned DistW  = 11;

  localparam logic [PulseW-1:0] PULSE_MAX = '1;
  localparam logic [MsW-1:0]    MS_MAX    = '1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TRIGGERED_MODE = 2'd0,
    CFG_PULSE_LIMIT_US = 2'd1,
    CFG_CYCLE_MS       = 2'd2
  } cfg_idx_e;

  localparam logic             RST_TRIGGERED_MODE = 1'b1;
  localparam logic [PulseW-1:0] RST_PULSE_LIMIT   = 16'd24000;
  localparam logic [MsW-1:0]    RST_CYCLE_MS      = 10'd60;

  // x / 58 as (x * ceil(2^22 / 58)) >> 22, exact for every 16-bit x
  localparam int unsigned DivShift = 22;
  localparam int unsigned DivMulW  = 17;
  localparam logic [DivMulW-1:0] DIV58_MUL = 17'd72316;

  function automatic logic [DistW-1:0] div58(input logic [PulseW-1:0] x);
    logic [PulseW+DivMulW-1:0] prod;
    prod = {{DivMulW{1'b0}}, x} * {{PulseW{1'b0}}, DIV58_MUL};
    return prod[DivShift +: DistW];
  endfunction

endpackage

// ===== rtl/uer_report_timer.sv =====
module uer_report_timer import uer_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tick_i,
  input  logic [MsW-1:0] cycle_ms_i,
  output logic           report_o
);

  localparam logic [MsW-1:0] PRESC_LAST = MsW'(TICKS_PER_MS - 1);

  logic [MsW-1:0] presc_q, presc_d;
  logic [MsW-1:0] ms_q, ms_d;
  logic [MsW-1:0] ms_inc;
  logic           wrap;

  assign wrap   = (presc_q >= PRESC_LAST);
  assign ms_inc = (ms_q != MS_MAX) ? ms_q + MsW'(1) : ms_q;

  always_comb begin
    presc_d  = presc_q;
    ms_d     = ms_q;
    report_o = 1'b0;
    if (tick_i) begin
      if (wrap) begin
        presc_d = '0;
        // a zero period compares like one
        if (ms_inc >= cycle_ms_i) begin
          ms_d     = '0;
          report_o = 1'b1;
        end else begin
          ms_d = ms_inc;
        end
      end else begin
        presc_d = presc_q + MsW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      ms_q    <= '0;
    end else begin
      presc_q <= presc_d;
      ms_q    <= ms_d;
    end
  end

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Each input transfer's result is registered in the output register.
// Throughput: one tick per cycle while the output is not stalled; the only loop is
// the state update (edge detect, pulse timer, millisecond timer, divide-by-58 multiply).
// A stalled output holds the result and blocks input until it is taken.
// Reset (asynchronous, active low) clears all timers and the stored width and
// loads the register defaults: triggered mode, 24000 us limit, 60 ms period.
module ultrasonic_echo_ranger import uer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] echo_level
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] trigger_out, [1] report_valid, [12:2] distance_cm
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic              trig_mode_q;
  logic [PulseW-1:0] limit_q;
  logic [MsW-1:0]    cycle_ms_q;

  logic              echo_prev_q, echo_prev_d;
  logic              active_q, active_d;
  logic [PulseW-1:0] ptimer_q, ptimer_d, ptimer_inc;
  logic [PulseW-1:0] accepted_q, accepted_d;
  logic [TrigW-1:0]  ttimer_q, ttimer_d;

  logic              out_valid_q;
  logic              out_trig_q, out_report_q;
  logic [DistW-1:0]  out_dist_q;

  logic              in_xfer;
  logic              echo;
  logic              report;
  logic              trig_now;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign echo          = s_axis_tdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_mode_q <= RST_TRIGGERED_MODE;
      limit_q     <= RST_PULSE_LIMIT;
      cycle_ms_q  <= RST_CYCLE_MS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIGGERED_MODE: trig_mode_q <= cfg_wdata_i[0];
        CFG_PULSE_LIMIT_US: limit_q     <= cfg_wdata_i;
        CFG_CYCLE_MS:       cycle_ms_q  <= cfg_wdata_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  uer_report_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (in_xfer),
    .cycle_ms_i (cycle_ms_q),
    .report_o   (report)
  );

  assign trig_now   = (ttimer_q != '0);
  assign ptimer_inc = (active_q && ptimer_q != PULSE_MAX) ? ptimer_q + PulseW'(1) : ptimer_q;

  always_comb begin
    echo_prev_d = echo_prev_q;
    active_d    = active_q;
    ptimer_d    = ptimer_q;
    accepted_d  = accepted_q;
    ttimer_d    = ttimer_q;
    if (in_xfer) begin
      echo_prev_d = echo;
      ptimer_d    = ptimer_inc;
      if (echo && !echo_prev_q) begin
        active_d = 1'b1;
        ptimer_d = '0;
      end else if (!echo && echo_prev_q && active_q) begin
        // falling edge with no rising edge seen is ignored
        if (ptimer_inc > PulseW'(MIN_PULSE_US) && ptimer_inc < limit_q) begin
          accepted_d = ptimer_inc;
        end else begin
          accepted_d = '0;
        end
        active_d = 1'b0;
      end
      if (report && trig_mode_q) begin
        ttimer_d = TrigW'(TRIGGER_TICKS);
      end else if (trig_now) begin
        ttimer_d = ttimer_q - TrigW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_prev_q <= 1'b0;
      active_q    <= 1'b0;
      ptimer_q    <= '0;
      accepted_q  <= '0;
      ttimer_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      echo_prev_q <= echo_prev_d;
      active_q    <= active_d;
      ptimer_q    <= ptimer_d;
      accepted_q  <= accepted_d;
      ttimer_q    <= ttimer_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, report carries the width stored on the same tick
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_trig_q   <= trig_now;
      out_report_q <= report;
      out_dist_q   <= report ? div58(accepted_d) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_dist_q, out_report_q, out_trig_q};

`ifndef SYNTHESIS
  a_dist_only_on_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_report_q |-> out_dist_q == '0)
    else $error("distance without report");

  a_trig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ttimer_q <= TrigW'(TRIGGER_TICKS))
    else $error("trigger timer out of range");

  a_accepted_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted_q == '0 || accepted_q > PulseW'(MIN_PULSE_US))
    else $error("stored width below minimum");

  a_trig_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && report && trig_mode_q |=> ttimer_q == TrigW'(TRIGGER_TICKS))
    else $error("trigger not started after report");
`endif

endmodule
